// ===== src/posting_list_merge_join_core_defines.svh =====
// Assertion macros used by the posting list merge join top level.
`ifndef POSTING_LIST_MERGE_JOIN_CORE_DEFINES_SVH
`define POSTING_LIST_MERGE_JOIN_CORE_DEFINES_SVH

// Checks a property at every clock edge outside reset.
`define PLMJ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define PLMJ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks that a condition implies a consequence in the next cycle.
`define PLMJ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/plmj_pkg.sv =====
// Types, constants and codes of the posting list merge join.
package plmj_pkg;

  localparam int unsigned LIST_DEPTH = 1024;
  localparam int unsigned ADDR_W     = $clog2(LIST_DEPTH);
  localparam int unsigned CNT_W      = $clog2(LIST_DEPTH + 1);

  localparam int unsigned DOC_W      = 24;
  localparam int unsigned POS_W      = 20;
  localparam int unsigned ENTRY_W    = DOC_W + POS_W;
  localparam int unsigned OP_W       = 3;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned S_DATA_W   = 48;
  localparam int unsigned M_DATA_W   = 48;
  localparam int unsigned M_USER_W   = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_APPEND_LEFT  = 2'd0,
    KIND_APPEND_RIGHT = 2'd1,
    KIND_PULL         = 2'd2,
    KIND_CLEAR        = 2'd3
  } kind_e;

  typedef enum logic [OP_W-1:0] {
    OP_INTERSECT  = 3'd0,
    OP_UNION      = 3'd1,
    OP_DIFFERENCE = 3'd2,
    OP_WITHIN     = 3'd3,
    OP_NEAR       = 3'd4
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OPERATION    = 2'd0,
    CFG_DISTANCE     = 2'd1,
    CFG_REPORT_RIGHT = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EVAL
  } state_e;

  // Document in the low bits, position above it.
  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [DOC_W-1:0] doc;
  } entry_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] max_gap;
    logic             report_right;
  } cfg_t;

  typedef struct packed {
    logic             adv_left;
    logic             adv_right;
    logic             res;
    logic             done;
    logic             set_match;
    logic [DOC_W-1:0] doc;
    logic [POS_W-1:0] pos;
  } step_t;

endpackage

// ===== src/plmj_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module plmj_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/plmj_step.sv =====
// One step of the two-pointer walk: compares the current entries and decides.
module plmj_step (
  input  plmj_pkg::cfg_t              cfg_i,
  input  logic                        left_avail_i,
  input  logic                        right_avail_i,
  input  plmj_pkg::entry_t            left_i,
  input  plmj_pkg::entry_t            right_i,
  input  logic                        match_valid_i,
  input  logic [plmj_pkg::DOC_W-1:0]  match_doc_i,
  output plmj_pkg::step_t             step_o
);

  import plmj_pkg::*;

  logic             la, ra;
  logic             doc_eq, doc_lt, doc_gt, pos_lt;
  logic [POS_W-1:0] gap;
  logic [POS_W:0]   pl_plus, pr_plus;
  logic [POS_W-1:0] hi_pos, lo_pos;

  assign la      = left_avail_i;
  assign ra      = right_avail_i;
  assign doc_eq  = left_i.doc == right_i.doc;
  assign doc_lt  = left_i.doc < right_i.doc;
  assign doc_gt  = right_i.doc < left_i.doc;
  assign pos_lt  = left_i.pos < right_i.pos;
  assign gap     = right_i.pos - left_i.pos;
  assign pl_plus = {1'b0, left_i.pos} + {1'b0, cfg_i.max_gap};
  assign pr_plus = {1'b0, right_i.pos} + {1'b0, cfg_i.max_gap};
  assign hi_pos  = pos_lt ? right_i.pos : left_i.pos;
  assign lo_pos  = pos_lt ? left_i.pos : right_i.pos;

  always_comb begin
    step_o = '0;
    if (!la && !ra) begin
      step_o.done = 1'b1;
    end else begin
      case (cfg_i.op)
        OP_INTERSECT: begin
          if (la && ra && doc_eq) begin
            step_o.set_match = 1'b1;
            step_o.res       = 1'b1;
            if (pos_lt) begin
              step_o.adv_left = 1'b1;
              step_o.doc      = left_i.doc;
              step_o.pos      = left_i.pos;
            end else begin
              step_o.adv_right = 1'b1;
              step_o.doc       = right_i.doc;
              step_o.pos       = right_i.pos;
            end
          end else if (la && (!ra || doc_lt)) begin
            step_o.adv_left = 1'b1;
            if (match_valid_i && match_doc_i == left_i.doc) begin
              step_o.res = 1'b1;
              step_o.doc = left_i.doc;
              step_o.pos = left_i.pos;
            end
          end else begin
            step_o.adv_right = 1'b1;
            if (match_valid_i && match_doc_i == right_i.doc) begin
              step_o.res = 1'b1;
              step_o.doc = right_i.doc;
              step_o.pos = right_i.pos;
            end
          end
        end
        OP_UNION: begin
          step_o.res = 1'b1;
          if (la && (!ra || doc_lt || (doc_eq && pos_lt))) begin
            step_o.adv_left = 1'b1;
            step_o.doc      = left_i.doc;
            step_o.pos      = left_i.pos;
          end else begin
            step_o.adv_right = 1'b1;
            step_o.doc       = right_i.doc;
            step_o.pos       = right_i.pos;
          end
        end
        OP_DIFFERENCE: begin
          if (!la) begin
            step_o.done = 1'b1;
          end else if (ra && doc_gt) begin
            step_o.adv_right = 1'b1;
          end else if (ra && doc_eq) begin
            step_o.adv_left = 1'b1;
          end else begin
            step_o.res      = 1'b1;
            step_o.adv_left = 1'b1;
            step_o.doc      = left_i.doc;
            step_o.pos      = left_i.pos;
          end
        end
        OP_WITHIN, OP_NEAR: begin
          if (!la || !ra) begin
            step_o.done = 1'b1;
          end else if (doc_lt) begin
            step_o.adv_left = 1'b1;
          end else if (doc_gt) begin
            step_o.adv_right = 1'b1;
          end else if (cfg_i.op == OP_WITHIN) begin
            if (right_i.pos < left_i.pos) begin
              step_o.adv_right = 1'b1;
            end else if (gap > cfg_i.max_gap) begin
              step_o.adv_left = 1'b1;
            end else begin
              step_o.res       = 1'b1;
              step_o.adv_left  = 1'b1;
              step_o.adv_right = 1'b1;
              step_o.doc       = left_i.doc;
              step_o.pos       = cfg_i.report_right ? right_i.pos : left_i.pos;
            end
          end else begin
            if ({1'b0, right_i.pos} > pl_plus) begin
              step_o.adv_left = 1'b1;
            end else if ({1'b0, left_i.pos} > pr_plus) begin
              step_o.adv_right = 1'b1;
            end else begin
              step_o.res       = 1'b1;
              step_o.adv_left  = 1'b1;
              step_o.adv_right = 1'b1;
              step_o.doc       = left_i.doc;
              step_o.pos       = cfg_i.report_right ? hi_pos : lo_pos;
            end
          end
        end
        default: begin
          step_o.done = 1'b1;
        end
      endcase
    end
  end

endmodule

// ===== src/posting_list_merge_join_core.sv =====
// Top level of the posting list merge join: list memories, walk sequencer, output register.
//
// Words on the slave side carry a kind in tuser: append left, append right, pull or clear.
// Appends write the entry into the left or right list memory and give no result word; an
// append to a full list is dropped and sets the sticky overflow flag. Clear empties both
// lists, rewinds the walk and drops the overflow flag; the registers keep their values.
// A pull gives exactly one word on the master side: the next entry of the walk with found
// set, or found clear and done_res set when the walk is exhausted.
// Appends and clears are taken in the idle state. A pull is accepted there and then runs
// walk steps, each a fetch state that reads both list memories and an eval state that
// compares the two entries, until a step gives a result or finds the walk exhausted.
// The fetch state is there because the list memory read port is registered.
// The output register lets the next word in while a result waits; when the receiver stalls
// with a result still held, a finishing pull waits in its compare step until the slot frees.
// Reset empties both lists, clears the walk state and the output valid flag, and sets the
// operation to intersect, the distance to one and the reported end to the left one.
// The configuration port writes a register at every clock edge with its write enable high.
module posting_list_merge_join_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [plmj_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [plmj_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // doc_id [23:0], position [43:24], zero [47:44]
  input  logic [plmj_pkg::S_DATA_W-1:0]       s_axis_tdata,
  // kind [1:0]
  input  logic [plmj_pkg::KIND_W-1:0]         s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // out_doc [23:0], out_position [43:24], overflow [44], zero [47:45]
  output logic [plmj_pkg::M_DATA_W-1:0]       m_axis_tdata,
  // found [0], done_res [1]
  output logic [plmj_pkg::M_USER_W-1:0]       m_axis_tuser
);

  import plmj_pkg::*;

  `include "posting_list_merge_join_core_defines.svh"

  state_e           state_q, state_d;
  logic [CNT_W-1:0] lc_q, lc_d, rc_q, rc_d, lp_q, lp_d, rp_q, rp_d;
  logic [DOC_W-1:0] md_q, md_d;
  logic             mv_q, mv_d, ovf_q, ovf_d;
  logic [OP_W-1:0]  op_q;
  logic [POS_W-1:0] dist_q;
  logic             rre_q;

  logic             out_valid_q, out_valid_d;
  logic             out_found_q, out_done_q, out_ovf_q;
  logic [DOC_W-1:0] out_doc_q;
  logic [POS_W-1:0] out_pos_q;

  logic             accept, eval_finish, eval_step;
  logic             left_full, right_full, we_left, we_right;
  kind_e            kind;
  entry_t           in_entry, left_rd, right_rd;
  cfg_t             cfg;
  step_t            step;

  assign kind       = kind_e'(s_axis_tuser);
  assign in_entry   = entry_t'(s_axis_tdata[ENTRY_W-1:0]);
  assign accept     = s_axis_tvalid && s_axis_tready;
  assign left_full  = lc_q == CNT_W'(LIST_DEPTH);
  assign right_full = rc_q == CNT_W'(LIST_DEPTH);
  assign we_left    = accept && kind == KIND_APPEND_LEFT && !left_full;
  assign we_right   = accept && kind == KIND_APPEND_RIGHT && !right_full;
  assign cfg        = '{op: op_q, max_gap: dist_q, report_right: rre_q};

  plmj_ram #(.WIDTH(ENTRY_W), .DEPTH(LIST_DEPTH)) u_left_ram (
    .clk_i   (clk_i),
    .we_i    (we_left),
    .waddr_i (lc_q[ADDR_W-1:0]),
    .wdata_i (in_entry),
    .raddr_i (lp_q[ADDR_W-1:0]),
    .rdata_o (left_rd)
  );

  plmj_ram #(.WIDTH(ENTRY_W), .DEPTH(LIST_DEPTH)) u_right_ram (
    .clk_i   (clk_i),
    .we_i    (we_right),
    .waddr_i (rc_q[ADDR_W-1:0]),
    .wdata_i (in_entry),
    .raddr_i (rp_q[ADDR_W-1:0]),
    .rdata_o (right_rd)
  );

  plmj_step u_step (
    .cfg_i         (cfg),
    .left_avail_i  (lp_q < lc_q),
    .right_avail_i (rp_q < rc_q),
    .left_i        (left_rd),
    .right_i       (right_rd),
    .match_valid_i (mv_q),
    .match_doc_i   (md_q),
    .step_o        (step)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && kind == KIND_PULL) begin
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (eval_finish) begin
          state_d = ST_IDLE;
        end else if (eval_step) begin
          state_d = ST_FETCH;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    eval_finish   = 1'b0;
    eval_step     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
      end
      ST_EVAL: begin
        eval_finish = (step.res || step.done) && (!out_valid_q || m_axis_tready);
        eval_step   = !step.res && !step.done;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  always_comb begin
    lc_d  = lc_q;
    rc_d  = rc_q;
    lp_d  = lp_q;
    rp_d  = rp_q;
    md_d  = md_q;
    mv_d  = mv_q;
    ovf_d = ovf_q;
    if (accept) begin
      case (kind)
        KIND_APPEND_LEFT: begin
          if (left_full) begin
            ovf_d = 1'b1;
          end else begin
            lc_d = lc_q + CNT_W'(1);
          end
        end
        KIND_APPEND_RIGHT: begin
          if (right_full) begin
            ovf_d = 1'b1;
          end else begin
            rc_d = rc_q + CNT_W'(1);
          end
        end
        KIND_CLEAR: begin
          lc_d  = '0;
          rc_d  = '0;
          lp_d  = '0;
          rp_d  = '0;
          md_d  = '0;
          mv_d  = 1'b0;
          ovf_d = 1'b0;
        end
        default: begin
          lc_d = lc_q;
        end
      endcase
    end
    if (eval_finish || eval_step) begin
      if (step.adv_left) begin
        lp_d = lp_q + CNT_W'(1);
      end
      if (step.adv_right) begin
        rp_d = rp_q + CNT_W'(1);
      end
      if (step.set_match) begin
        md_d = left_rd.doc;
        mv_d = 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (eval_finish) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      lc_q        <= '0;
      rc_q        <= '0;
      lp_q        <= '0;
      rp_q        <= '0;
      md_q        <= '0;
      mv_q        <= 1'b0;
      ovf_q       <= 1'b0;
      op_q        <= OP_INTERSECT;
      dist_q      <= POS_W'(1);
      rre_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lc_q        <= lc_d;
      rc_q        <= rc_d;
      lp_q        <= lp_d;
      rp_q        <= rp_d;
      md_q        <= md_d;
      mv_q        <= mv_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_OPERATION:    op_q   <= cfg_data_i[OP_W-1:0];
          CFG_DISTANCE:     dist_q <= cfg_data_i[POS_W-1:0];
          CFG_REPORT_RIGHT: rre_q  <= cfg_data_i[0];
          default:          rre_q  <= rre_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (eval_finish) begin
      out_found_q <= step.res;
      out_done_q  <= !step.res;
      out_doc_q   <= step.res ? step.doc : '0;
      out_pos_q   <= step.res ? step.pos : '0;
      out_ovf_q   <= ovf_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(M_DATA_W - ENTRY_W - 1)'(0), out_ovf_q, out_pos_q, out_doc_q};
  assign m_axis_tuser  = {out_done_q, out_found_q};

  `PLMJ_ASSERT(a_ptr_le_cnt,
    lp_q <= lc_q && rp_q <= rc_q && lc_q <= CNT_W'(LIST_DEPTH) && rc_q <= CNT_W'(LIST_DEPTH),
    "walk pointer beyond list fill or fill beyond depth")
  `PLMJ_ASSERT_NEXT(a_step_advances, eval_step,
    lp_q != $past(lp_q) || rp_q != $past(rp_q), "walk step moved no pointer")
  `PLMJ_ASSERT_IMP(a_found_xor_done, m_axis_tvalid,
    out_found_q != out_done_q, "found and done_res not complementary")
  `PLMJ_ASSERT_IMP(a_empty_zero, m_axis_tvalid && !out_found_q,
    out_doc_q == '0 && out_pos_q == '0, "empty result carries nonzero entry")
  `PLMJ_ASSERT_IMP(a_write_idle, we_left || we_right,
    state_q == ST_IDLE, "list write outside idle state")

endmodule

// ===== bench/tb_top.sv =====
// Self-checking stream testbench for posting_list_merge_join_core with its own join predictor.
`timescale 1ns / 100ps

module tb_top;
  import plmj_pkg::*;

  localparam int unsigned QUIET_LIMIT   = 20000;
  localparam int unsigned HOLD_CYCLES   = 600;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned RANDOM_WORDS  = 160;
  localparam logic [DOC_W-1:0] DOC_MAX  = '1;
  localparam logic [POS_W-1:0] POS_MAX  = '1;

  typedef struct packed {
    logic             found;
    logic             done;
    logic [DOC_W-1:0] doc;
    logic [POS_W-1:0] pos;
    logic             overflow;
  } hit_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_DATA_W-1:0]   s_axis_tdata  = '0;
  logic [KIND_W-1:0]     s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0]   m_axis_tdata;
  logic [M_USER_W-1:0]   m_axis_tuser;

  // Predictor state: both lists, the walk and the registers.
  entry_t           left_mem [LIST_DEPTH];
  entry_t           right_mem[LIST_DEPTH];
  int unsigned      left_len, right_len, left_idx, right_idx;
  logic [DOC_W-1:0] match_doc;
  logic             match_on;
  logic             dropped_flag;
  logic [OP_W-1:0]  join_op;
  logic [POS_W-1:0] gap_limit;
  logic             report_late;

  hit_t        hits_due[$];
  int unsigned error_count    = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic        rx_holding     = 1'b0;
  event        rx_hold_ev;

  posting_list_merge_join_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  function automatic void clear_walk();
    left_len     = 0;
    right_len    = 0;
    left_idx     = 0;
    right_idx    = 0;
    match_doc    = '0;
    match_on     = 1'b0;
    dropped_flag = 1'b0;
  endfunction

  // Advances the two-pointer walk to the next result entry, or returns 0 when exhausted.
  function automatic logic next_hit(output logic [DOC_W-1:0] d, output logic [POS_W-1:0] p);
    logic   la, ra;
    entry_t l, r;
    d = '0;
    p = '0;
    forever begin
      la = left_idx < left_len;
      ra = right_idx < right_len;
      l  = la ? left_mem[left_idx] : '0;
      r  = ra ? right_mem[right_idx] : '0;
      if (!la && !ra) return 1'b0;
      case (join_op)
        OP_INTERSECT: begin
          if (la && ra && l.doc == r.doc) begin
            match_doc = l.doc;
            match_on  = 1'b1;
            if (l.pos < r.pos) begin
              d = l.doc; p = l.pos; left_idx++;
            end else begin
              d = r.doc; p = r.pos; right_idx++;
            end
            return 1'b1;
          end
          if (la && (!ra || l.doc < r.doc)) begin
            left_idx++;
            if (match_on && match_doc == l.doc) begin
              d = l.doc; p = l.pos;
              return 1'b1;
            end
          end else begin
            right_idx++;
            if (match_on && match_doc == r.doc) begin
              d = r.doc; p = r.pos;
              return 1'b1;
            end
          end
        end
        OP_UNION: begin
          if (la && (!ra || l.doc < r.doc || (l.doc == r.doc && l.pos < r.pos))) begin
            d = l.doc; p = l.pos; left_idx++;
          end else begin
            d = r.doc; p = r.pos; right_idx++;
          end
          return 1'b1;
        end
        OP_DIFFERENCE: begin
          if (!la) return 1'b0;
          if (ra && r.doc < l.doc) begin
            right_idx++;
          end else if (ra && r.doc == l.doc) begin
            left_idx++;
          end else begin
            d = l.doc; p = l.pos; left_idx++;
            return 1'b1;
          end
        end
        OP_WITHIN, OP_NEAR: begin
          if (!la || !ra) return 1'b0;
          if (l.doc < r.doc) begin
            left_idx++;
          end else if (r.doc < l.doc) begin
            right_idx++;
          end else if (join_op == OP_WITHIN) begin
            if (r.pos < l.pos) begin
              right_idx++;
            end else if (r.pos - l.pos > gap_limit) begin
              left_idx++;
            end else begin
              d = l.doc; p = report_late ? r.pos : l.pos;
              left_idx++; right_idx++;
              return 1'b1;
            end
          end else begin
            if ({1'b0, r.pos} > {1'b0, l.pos} + {1'b0, gap_limit}) begin
              left_idx++;
            end else if ({1'b0, l.pos} > {1'b0, r.pos} + {1'b0, gap_limit}) begin
              right_idx++;
            end else begin
              d = l.doc;
              if (report_late) p = (l.pos > r.pos) ? l.pos : r.pos;
              else p = (l.pos > r.pos) ? r.pos : l.pos;
              left_idx++; right_idx++;
              return 1'b1;
            end
          end
        end
        default: return 1'b0;
      endcase
    end
  endfunction

  function automatic void predict_word(kind_e kind, logic [DOC_W-1:0] doc, logic [POS_W-1:0] pos);
    logic             f;
    logic [DOC_W-1:0] d;
    logic [POS_W-1:0] p;
    hit_t             h;
    case (kind)
      KIND_APPEND_LEFT: begin
        if (left_len >= LIST_DEPTH) dropped_flag = 1'b1;
        else begin
          left_mem[left_len] = '{pos: pos, doc: doc};
          left_len++;
        end
      end
      KIND_APPEND_RIGHT: begin
        if (right_len >= LIST_DEPTH) dropped_flag = 1'b1;
        else begin
          right_mem[right_len] = '{pos: pos, doc: doc};
          right_len++;
        end
      end
      KIND_CLEAR: clear_walk();
      default: begin
        f = next_hit(d, p);
        h = '{found: f, done: !f, doc: f ? d : '0, pos: f ? p : '0, overflow: dropped_flag};
        hits_due.insert(hits_due.size(), h);
      end
    endcase
  endfunction

  task automatic send_word(input kind_e kind, input logic [DOC_W-1:0] doc,
                           input logic [POS_W-1:0] pos);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {{(S_DATA_W - ENTRY_W){1'b0}}, pos, doc};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_word(kind, doc, pos);
  endtask

  // Drops the input valid, waits until every pending result has arrived, then lets the block settle.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (hits_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic configure(input logic [OP_W-1:0] op, input logic [POS_W-1:0] gap,
                           input logic late);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_OPERATION;
    cfg_data_i  <= CFG_DATA_W'(op);
    @(posedge clk_i);
    cfg_index_i <= CFG_DISTANCE;
    cfg_data_i  <= CFG_DATA_W'(gap);
    @(posedge clk_i);
    cfg_index_i <= CFG_REPORT_RIGHT;
    cfg_data_i  <= CFG_DATA_W'(late);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    join_op     = op;
    gap_limit   = gap;
    report_late = late;
  endtask

  task automatic pull_words(input int unsigned count);
    repeat (count) send_word(KIND_PULL, '0, '0);
  endtask

  task automatic test_reset_state();
    pull_words(1);
    send_word(KIND_APPEND_LEFT, 24'd5, 20'd7);
    send_word(KIND_APPEND_RIGHT, 24'd5, 20'd7);
    pull_words(3);
  endtask

  task automatic test_intersect_then_union();
    configure(OP_INTERSECT, 20'd1, 1'b0);
    send_word(KIND_CLEAR, '0, '0);
    send_word(KIND_APPEND_LEFT, 24'd0, 20'd0);
    send_word(KIND_APPEND_LEFT, 24'd3, 20'd2);
    send_word(KIND_APPEND_LEFT, 24'd3, 20'd8);
    send_word(KIND_APPEND_LEFT, 24'd3, 20'd9);
    send_word(KIND_APPEND_LEFT, DOC_MAX, POS_MAX);
    send_word(KIND_APPEND_RIGHT, 24'd1, 20'd5);
    send_word(KIND_APPEND_RIGHT, 24'd3, 20'd4);
    send_word(KIND_APPEND_RIGHT, DOC_MAX, POS_MAX);
    pull_words(3);
    configure(OP_UNION, 20'd1, 1'b0);
    pull_words(4);
    send_word(KIND_APPEND_RIGHT, DOC_MAX, 20'd0);
    pull_words(2);
  endtask

  task automatic test_difference();
    configure(OP_DIFFERENCE, 20'd1, 1'b0);
    send_word(KIND_CLEAR, '0, '0);
    send_word(KIND_APPEND_LEFT, 24'd2, 20'd1);
    send_word(KIND_APPEND_LEFT, 24'd4, 20'd1);
    send_word(KIND_APPEND_LEFT, 24'd9, 20'd0);
    send_word(KIND_APPEND_RIGHT, 24'd1, 20'd0);
    send_word(KIND_APPEND_RIGHT, 24'd4, 20'd5);
    pull_words(4);
  endtask

  task automatic test_distance_joins();
    configure(OP_WITHIN, POS_MAX, 1'b1);
    send_word(KIND_CLEAR, '0, '0);
    send_word(KIND_APPEND_LEFT, 24'd7, 20'd0);
    send_word(KIND_APPEND_LEFT, 24'd8, POS_MAX);
    send_word(KIND_APPEND_RIGHT, 24'd7, POS_MAX);
    send_word(KIND_APPEND_RIGHT, 24'd8, 20'd0);
    pull_words(2);
    configure(OP_NEAR, 20'd0, 1'b0);
    send_word(KIND_CLEAR, '0, '0);
    send_word(KIND_APPEND_LEFT, 24'd7, 20'd5);
    send_word(KIND_APPEND_LEFT, DOC_MAX, POS_MAX);
    send_word(KIND_APPEND_RIGHT, 24'd7, 20'd5);
    send_word(KIND_APPEND_RIGHT, DOC_MAX, 20'd0);
    pull_words(2);
    configure(OP_NEAR, POS_MAX, 1'b1);
    send_word(KIND_APPEND_LEFT, DOC_MAX, POS_MAX);
    send_word(KIND_APPEND_RIGHT, DOC_MAX, 20'd0);
    pull_words(2);
  endtask

  task automatic test_unused_operations();
    send_word(KIND_CLEAR, '0, '0);
    send_word(KIND_APPEND_LEFT, 24'd1, 20'd1);
    for (int code = int'(OP_NEAR) + 1; code < (1 << OP_W); code++) begin
      configure(OP_W'(code), 20'd1, 1'b0);
      pull_words(1);
    end
    configure(OP_UNION, 20'd1, 1'b0);
    pull_words(2);
  endtask

  task automatic test_full_lists();
    configure(OP_INTERSECT, 20'd1, 1'b0);
    send_word(KIND_CLEAR, '0, '0);
    for (int unsigned i = 0; i < LIST_DEPTH; i++) begin
      send_word(KIND_APPEND_LEFT, DOC_W'(2 * i), POS_W'(i));
    end
    for (int unsigned i = 0; i < 4; i++) begin
      send_word(KIND_APPEND_RIGHT, DOC_W'(2 * i + 1), POS_W'(i));
    end
    pull_words(1);
    send_word(KIND_APPEND_LEFT, DOC_MAX, POS_MAX);
    send_word(KIND_APPEND_RIGHT, DOC_MAX, POS_MAX);
    pull_words(1);
    configure(OP_UNION, 20'd1, 1'b0);
    pull_words(1);
    send_word(KIND_CLEAR, '0, '0);
    pull_words(1);
  endtask

  task automatic test_output_backpressure();
    configure(OP_UNION, 20'd1, 1'b0);
    send_word(KIND_CLEAR, '0, '0);
    for (int unsigned i = 0; i < 12; i++) begin
      send_word(KIND_APPEND_LEFT, DOC_W'(i), 20'd0);
      send_word(KIND_APPEND_RIGHT, DOC_W'(i), 20'd1);
    end
    -> rx_hold_ev;
    pull_words(20);
  endtask

  // One random data set: mostly sorted lists with overlapping documents, sometimes noise.
  task automatic random_set(inout int unsigned sent);
    logic [ENTRY_W-1:0] lefts[$], rights[$];
    logic [ENTRY_W-1:0] e;
    logic [DOC_W-1:0]   doc_base, d;
    logic [POS_W-1:0]   pos_base, p, gap_max;
    int unsigned        doc_span, pos_span, roll, pulls;
    logic [OP_W-1:0]    op;
    roll = $urandom_range(0, 99);
    case ($urandom_range(0, 4))
      0: gap_max = '0;
      1: gap_max = 20'd1;
      2: gap_max = POS_W'($urandom_range(2, 64));
      3: gap_max = POS_W'($urandom());
      default: gap_max = POS_MAX;
    endcase
    if ($urandom_range(0, 19) == 0) op = OP_W'($urandom_range(int'(OP_NEAR) + 1, 7));
    else op = OP_W'($urandom_range(0, int'(OP_NEAR)));
    configure(op, gap_max, 1'($urandom_range(0, 1)));
    if (roll < 15) begin
      repeat ($urandom_range(4, 16)) begin
        send_word(kind_e'($urandom_range(0, 3)), DOC_W'($urandom()), POS_W'($urandom()));
        sent++;
      end
      return;
    end
    if ($urandom_range(0, 9) != 0) begin
      send_word(KIND_CLEAR, DOC_W'($urandom()), POS_W'($urandom()));
      sent++;
    end
    case ($urandom_range(0, 2))
      0: doc_span = 2;
      1: doc_span = 6;
      default: doc_span = 40;
    endcase
    case ($urandom_range(0, 2))
      0: pos_span = 3;
      1: pos_span = 30;
      default: pos_span = int'(POS_MAX);
    endcase
    doc_base = DOC_W'($urandom_range(0, int'(DOC_MAX) - doc_span));
    pos_base = POS_W'($urandom_range(0, int'(POS_MAX) - pos_span));
    repeat ($urandom_range(0, 12)) begin
      d = doc_base + DOC_W'($urandom_range(0, doc_span));
      p = pos_base + POS_W'($urandom_range(0, pos_span));
      lefts.insert(lefts.size(), {d, p});
    end
    repeat ($urandom_range(0, 12)) begin
      d = doc_base + DOC_W'($urandom_range(0, doc_span));
      p = pos_base + POS_W'($urandom_range(0, pos_span));
      rights.insert(rights.size(), {d, p});
    end
    lefts.sort();
    rights.sort();
    if (roll < 25 && lefts.size() > 1) begin
      e = lefts[0];
      lefts[0] = lefts[lefts.size() - 1];
      lefts[lefts.size() - 1] = e;
    end
    pulls = lefts.size() + rights.size() + $urandom_range(1, 3);
    while (lefts.size() + rights.size() != 0) begin
      if (rights.size() == 0 || (lefts.size() != 0 && $urandom_range(0, 1) == 0)) begin
        e = lefts.pop_front();
        send_word(KIND_APPEND_LEFT, e[ENTRY_W-1:POS_W], e[POS_W-1:0]);
      end else begin
        e = rights.pop_front();
        send_word(KIND_APPEND_RIGHT, e[ENTRY_W-1:POS_W], e[POS_W-1:0]);
      end
      sent++;
    end
    if ($urandom_range(0, 4) == 0) begin
      pull_words(pulls / 2);
      sent += pulls / 2;
      configure(OP_W'($urandom_range(0, int'(OP_NEAR))), gap_max, 1'($urandom_range(0, 1)));
      pulls -= pulls / 2;
    end
    pull_words(pulls);
    sent += pulls;
  endtask

  task automatic test_random_traffic();
    int unsigned sent;
    for (int phase = 0; phase < 4; phase++) begin
      settle();
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      sent = 0;
      while (sent < RANDOM_WORDS / 4) random_set(sent);
    end
  endtask

  initial begin
    clear_walk();
    join_op     = OP_INTERSECT;
    gap_limit   = 20'd1;
    report_late = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_intersect_then_union();
    test_difference();
    test_distance_joins();
    test_unused_operations();
    test_full_lists();
    test_output_backpressure();
    test_random_traffic();
    settle();
    repeat (16) @(posedge clk_i);
    if (error_count == 0) begin
      $display("** posting_list_merge_join_core: PASSED **");
    end else begin
      $display("** posting_list_merge_join_core: FAILED **");
    end
    $finish;
  end

  initial forever begin
    @(rx_hold_ev);
    @(negedge clk_i);
    rx_holding = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk_i);
    rx_holding = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= !rx_holding && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    hit_t want, got;
    if (m_axis_tvalid && m_axis_tready) begin
      got = '{found: m_axis_tuser[0], done: m_axis_tuser[1], doc: m_axis_tdata[DOC_W-1:0],
              pos: m_axis_tdata[ENTRY_W-1:DOC_W], overflow: m_axis_tdata[ENTRY_W]};
      if (hits_due.size() == 0) begin
        error_count++;
        $display("%0t: result word %h arrived with none expected", $time, got);
      end else begin
        want = hits_due.pop_front();
        check_field("found", 32'(want.found), 32'(got.found));
        check_field("done_res", 32'(want.done), 32'(got.done));
        check_field("out_doc", 32'(want.doc), 32'(got.doc));
        check_field("out_position", 32'(want.pos), 32'(got.pos));
        check_field("overflow", 32'(want.overflow), 32'(got.overflow));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("** posting_list_merge_join_core: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
